### rtl/utcl_pkg.sv
// ============================================================================
// utcl_pkg
// Shared types, constants and helper functions for the UTC to local time
// converter pipeline.
// ============================================================================
package utcl_pkg;

  // Config register indexes
  localparam logic CFG_UTC_OFFSET = 1'b0;
  localparam logic CFG_DST_ENABLE = 1'b1;

  // Two-digit years below this pivot belong to the 2000s
  localparam logic [6:0] YEAR_PIVOT      = 7'd80;
  localparam logic [7:0] YEAR_CENTURY    = 8'd100;
  localparam logic [6:0] DST_ZERO_CODE   = 7'd100;
  localparam logic [6:0] DST_LAST_SOLID  = 7'd50;
  localparam logic [7:0] DST_LATE_CODE   = 8'd51;
  localparam logic [7:0] DST_EARLY_CODE  = 8'd1;
  localparam logic [4:0] DST_SWITCH_HOUR = 5'd2;
  localparam logic [6:0] HOURS_PER_DAY   = 7'd24;
  localparam logic [11:0] BASE_YEAR      = 12'd1900;
  localparam logic [3:0] LAST_MONTH      = 4'd12;
  localparam logic [5:0] CENTURY_19_BCD  = 6'h19;
  localparam logic [5:0] CENTURY_20_BCD  = 6'h20;

  localparam logic [4:0] MONTH_LEN [13] = '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31,
                                            5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30,
                                            5'd31};

  // Stage 1 -> stage 2: normalized fields, offset-adjusted hour
  typedef struct packed {
    logic [7:0] yr;        // years since 1900
    logic [3:0] mo;
    logic [4:0] day;
    logic [6:0] hr;        // signed hour after offset
    logic [6:0] dst;
    logic       late_en;   // transition-day correction still pending
    logic [4:0] dim_cur;   // length of current month
    logic [4:0] dim_prev;  // length of previous month
    logic [5:0] min;
    logic [5:0] sec;
  } prep_t;

  // Stage 2 -> stage 3: date after day carry or borrow
  typedef struct packed {
    logic [7:0] yr;
    logic [3:0] mo;
    logic [4:0] day;
    logic [4:0] hr;
    logic [7:0] dst;
    logic       late_en;
    logic [5:0] min;
    logic [5:0] sec;
  } date_t;

  // Month length; out-of-range months count as 31 days
  function automatic logic [4:0] days_in(input logic [3:0] mo, input logic leap);
    logic [4:0] d;
    if (mo < 4'd1 || mo > LAST_MONTH) begin
      d = 5'd31;
    end else if (mo == 4'd2 && leap) begin
      d = 5'd29;
    end else begin
      d = MONTH_LEN[mo];
    end
    return d;
  endfunction

  // Packed BCD of a value up to 99
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] units;
    tens = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 7'(k * 10)) tens = 4'(k);
    end
    units = v - ({3'd0, tens} * 7'd10);
    return {tens, units[3:0]};
  endfunction

endpackage

### rtl/utcl_prep.sv
// ============================================================================
// utcl_prep
// Stage 1: year pivot, day-code fixup, hour offset and solid daylight hour,
// month lengths for the following carry or borrow.
// ============================================================================
module utcl_prep import utcl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [6:0]  year_two_digit,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  input  logic [4:0]  hour_in,
  input  logic [5:0]  minute_in,
  input  logic [5:0]  second_in,
  input  logic [6:0]  dst_code,
  input  logic [4:0]  utc_offset_hours,
  input  logic        dst_enable,
  output logic        s1_valid,
  output prep_t       s1,
  input  logic        s1_ready
);

  prep_t      s1_next;
  logic [6:0] dst_fix;
  logic       early;
  logic       leap;
  logic [3:0] mo_prev;

  assign in_ready = !s1_valid || s1_ready;

  // Field normalization and hour offset
  always_comb begin
    leap    = (year_two_digit[1:0] == 2'b00);
    dst_fix = (dst_code == 7'd0) ? DST_ZERO_CODE : dst_code;
    early   = dst_enable && (dst_fix <= DST_LAST_SOLID) && (dst_fix > 7'd1);
    mo_prev = (month_in <= 4'd1) ? LAST_MONTH : month_in - 4'd1;

    s1_next.yr       = (year_two_digit < YEAR_PIVOT) ? {1'b0, year_two_digit} + YEAR_CENTURY
                                                     : {1'b0, year_two_digit};
    s1_next.mo       = month_in;
    s1_next.day      = day_in;
    s1_next.hr       = {2'b00, hour_in} + {{2{utc_offset_hours[4]}}, utc_offset_hours}
                       + {6'd0, early};
    s1_next.dst      = dst_fix;
    s1_next.late_en  = dst_enable && !early;
    s1_next.dim_cur  = days_in(month_in, leap);
    s1_next.dim_prev = days_in(mo_prev, leap);
    s1_next.min      = minute_in;
    s1_next.sec      = second_in;
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1 <= s1_next;
    end
  end

endmodule

### rtl/utcl_date.sv
// ============================================================================
// utcl_date
// Stage 2: bring the hour into 0..23 and carry or borrow one day across
// month and year, moving the day code along.
// ============================================================================
module utcl_date import utcl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s1_valid,
  input  prep_t s1,
  output logic  s1_ready,
  output logic  s2_valid,
  output date_t s2,
  input  logic  s2_ready
);

  date_t      s2_next;
  logic       hr_neg;
  logic       hr_over;
  logic [5:0] day_inc;

  assign s1_ready = !s2_valid || s2_ready;

  // Day carry / borrow
  always_comb begin
    hr_neg  = s1.hr[6];
    hr_over = !s1.hr[6] && (s1.hr > 7'd23);
    day_inc = {1'b0, s1.day} + 6'd1;

    s2_next.yr      = s1.yr;
    s2_next.mo      = s1.mo;
    s2_next.day     = s1.day;
    s2_next.hr      = s1.hr[4:0];
    s2_next.dst     = {1'b0, s1.dst};
    s2_next.late_en = s1.late_en;
    s2_next.min     = s1.min;
    s2_next.sec     = s1.sec;

    if (hr_neg) begin
      s2_next.hr  = 5'(s1.hr + HOURS_PER_DAY);
      s2_next.dst = {1'b0, s1.dst} + 8'd1;
      if (s1.day <= 5'd1) begin
        s2_next.day = s1.dim_prev;
        if (s1.mo <= 4'd1) begin
          s2_next.mo = LAST_MONTH;
          s2_next.yr = s1.yr - 8'd1;
        end else begin
          s2_next.mo = s1.mo - 4'd1;
        end
      end else begin
        s2_next.day = s1.day - 5'd1;
      end
    end else if (hr_over) begin
      s2_next.hr  = 5'(s1.hr - HOURS_PER_DAY);
      s2_next.dst = {1'b0, s1.dst} - 8'd1;
      if (day_inc > {1'b0, s1.dim_cur}) begin
        s2_next.day = 5'd1;
        if (s1.mo >= LAST_MONTH) begin
          s2_next.mo = 4'd1;
          s2_next.yr = s1.yr + 8'd1;
        end else begin
          s2_next.mo = s1.mo + 4'd1;
        end
      end else begin
        s2_next.day = day_inc[4:0];
      end
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2 <= s2_next;
    end
  end

endmodule

### rtl/utcl_fmt.sv
// ============================================================================
// utcl_fmt
// Stage 3: transition-day hour, four-digit year and packed BCD fields.
// Holds the output register.
// ============================================================================
module utcl_fmt import utcl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s2_valid,
  input  date_t       s2,
  output logic        s2_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] year_full,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [4:0]  hour_out,
  output logic [5:0]  century_bcd,
  output logic [7:0]  year_bcd,
  output logic [4:0]  month_bcd,
  output logic [5:0]  day_bcd,
  output logic [5:0]  hour_bcd,
  output logic [6:0]  minute_bcd,
  output logic [6:0]  second_bcd
);

  logic       late_hit;
  logic [4:0] hr_fin;
  logic       cent20;
  logic [6:0] yr_low;
  logic [7:0] mo_b;
  logic [7:0] day_b;
  logic [7:0] hr_b;
  logic [7:0] min_b;
  logic [7:0] sec_b;
  logic [7:0] yr_b;

  assign s2_ready = !out_valid || out_ready;

  // Transition hour and BCD digits
  always_comb begin
    late_hit = s2.late_en &&
               (((s2.dst == DST_LATE_CODE) && (s2.hr >= DST_SWITCH_HOUR)) ||
                ((s2.dst == DST_EARLY_CODE) && (s2.hr < DST_SWITCH_HOUR)));
    hr_fin   = s2.hr + {4'd0, late_hit};
    cent20   = (s2.yr >= YEAR_CENTURY);
    yr_low   = cent20 ? 7'(s2.yr - YEAR_CENTURY) : s2.yr[6:0];
    yr_b     = to_bcd(yr_low);
    mo_b     = to_bcd({3'd0, s2.mo});
    day_b    = to_bcd({2'd0, s2.day});
    hr_b     = to_bcd({2'd0, hr_fin});
    min_b    = to_bcd({1'b0, s2.min});
    sec_b    = to_bcd({1'b0, s2.sec});
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      year_full   <= {4'd0, s2.yr} + BASE_YEAR;
      month_out   <= s2.mo;
      day_out     <= s2.day;
      hour_out    <= hr_fin;
      century_bcd <= cent20 ? CENTURY_20_BCD : CENTURY_19_BCD;
      year_bcd    <= yr_b;
      month_bcd   <= mo_b[4:0];
      day_bcd     <= day_b[5:0];
      hour_bcd    <= hr_b[5:0];
      minute_bcd  <= min_b[6:0];
      second_bcd  <= sec_b[6:0];
    end
  end

endmodule

### rtl/utc_to_local_time_with_dst_core.sv
// ============================================================================
// utc_to_local_time_with_dst_core
// Converts a parsed broadcast UTC timestamp to local date and time with
// hour offset and daylight saving correction, in binary and packed BCD.
// ============================================================================
//
//   channel   signals                         dir   notes
//   -------   -----------------------------   ---   -------------------------
//   input     in_valid / in_ready + fields    in    one timestamp per request
//   output    out_valid / out_ready + fields  out   one result per request
//   config    cfg_we, cfg_index, cfg_data     in    0: offset, 1: dst enable
//
// Three register stages (prep, date carry, format); a request accepted into prep
// passes through the date carry register to the format register, which drives
// out_valid, and one request is taken every cycle while out_ready does not stall.
// Each stage advances when the stage after it is empty or moving, so a stall
// on out_ready backs up without loss; bubbles fill while out_ready is low.
// Synchronous reset empties the pipeline and clears offset and dst enable.
// ============================================================================
module utc_to_local_time_with_dst_core import utcl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [6:0]  year_two_digit,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  input  logic [4:0]  hour_in,
  input  logic [5:0]  minute_in,
  input  logic [5:0]  second_in,
  input  logic [6:0]  dst_code,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] year_full,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [4:0]  hour_out,
  output logic [5:0]  century_bcd,
  output logic [7:0]  year_bcd,
  output logic [4:0]  month_bcd,
  output logic [5:0]  day_bcd,
  output logic [5:0]  hour_bcd,
  output logic [6:0]  minute_bcd,
  output logic [6:0]  second_bcd
);

  logic [4:0] utc_offset_hours;
  logic       dst_enable;
  logic       s1_valid;
  logic       s1_ready;
  prep_t      s1;
  logic       s2_valid;
  logic       s2_ready;
  date_t      s2;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      utc_offset_hours <= 5'd0;
      dst_enable       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UTC_OFFSET: utc_offset_hours <= cfg_data;
        CFG_DST_ENABLE: dst_enable       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline stages
  utcl_prep u_prep (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .year_two_digit   (year_two_digit),
    .month_in         (month_in),
    .day_in           (day_in),
    .hour_in          (hour_in),
    .minute_in        (minute_in),
    .second_in        (second_in),
    .dst_code         (dst_code),
    .utc_offset_hours (utc_offset_hours),
    .dst_enable       (dst_enable),
    .s1_valid         (s1_valid),
    .s1               (s1),
    .s1_ready         (s1_ready)
  );

  utcl_date u_date (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_ready (s1_ready),
    .s2_valid (s2_valid),
    .s2       (s2),
    .s2_ready (s2_ready)
  );

  utcl_fmt u_fmt (
    .clk         (clk),
    .rst         (rst),
    .s2_valid    (s2_valid),
    .s2          (s2),
    .s2_ready    (s2_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .year_full   (year_full),
    .month_out   (month_out),
    .day_out     (day_out),
    .hour_out    (hour_out),
    .century_bcd (century_bcd),
    .year_bcd    (year_bcd),
    .month_bcd   (month_bcd),
    .day_bcd     (day_bcd),
    .hour_bcd    (hour_bcd),
    .minute_bcd  (minute_bcd),
    .second_bcd  (second_bcd)
  );

`ifndef SYNTHESIS
  // Pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // Local hour never exceeds 24
  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hour_out <= 5'd24))
    else $error("local hour out of range");

  // Century BCD agrees with the binary year
  a_century: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((century_bcd == CENTURY_20_BCD) == (year_full >= 12'd2000)))
    else $error("century BCD does not match year");

  // Year-within-century units digit is a decimal digit
  a_year_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (year_bcd[3:0] <= 4'd9))
    else $error("year BCD digit invalid");
`endif

endmodule

### test/tb_utc_to_local_time_with_dst_core.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_utc_to_local_time_with_dst_core
// Self-checking bench for the UTC to local time converter. A scoreboard
// predicts the local date and time for every accepted request, using its
// own copy of the offset and daylight saving registers. Each accepted result
// is then compared field by field. Directed timestamps cover year, month and
// day edges and the transition days. Random timestamps then run under
// several register settings and back-pressure patterns.
// ============================================================================
module tb_utc_to_local_time_with_dst_core;
  import utcl_pkg::*;

  localparam int MAX_CYCLES  = 200000;

  // one parsed UTC timestamp, at port widths
  typedef struct packed {
    logic [6:0] yr;
    logic [3:0] mo;
    logic [4:0] day;
    logic [4:0] hr;
    logic [5:0] minute;
    logic [5:0] second;
    logic [6:0] code;
  } utc_t;

  // one local time result, at port widths
  typedef struct packed {
    logic [11:0] year_full;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  century_bcd;
    logic [7:0]  year_bcd;
    logic [4:0]  month_bcd;
    logic [5:0]  day_bcd;
    logic [5:0]  hour_bcd;
    logic [6:0]  minute_bcd;
    logic [6:0]  second_bcd;
  } wall_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [4:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [6:0]  year_two_digit;
  logic [3:0]  month_in;
  logic [4:0]  day_in;
  logic [4:0]  hour_in;
  logic [5:0]  minute_in;
  logic [5:0]  second_in;
  logic [6:0]  dst_code;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] year_full;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  century_bcd;
  logic [7:0]  year_bcd;
  logic [4:0]  month_bcd;
  logic [5:0]  day_bcd;
  logic [5:0]  hour_bcd;
  logic [6:0]  minute_bcd;
  logic [6:0]  second_bcd;

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_cycles;
  int cycle_cnt;

  utc_to_local_time_with_dst_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .year_two_digit (year_two_digit),
    .month_in       (month_in),
    .day_in         (day_in),
    .hour_in        (hour_in),
    .minute_in      (minute_in),
    .second_in      (second_in),
    .dst_code       (dst_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .year_full      (year_full),
    .month_out      (month_out),
    .day_out        (day_out),
    .hour_out       (hour_out),
    .century_bcd    (century_bcd),
    .year_bcd       (year_bcd),
    .month_bcd      (month_bcd),
    .day_bcd        (day_bcd),
    .hour_bcd       (hour_bcd),
    .minute_bcd     (minute_bcd),
    .second_bcd     (second_bcd)
  );

  // days in a month; anything outside 1..12 counts as 31
  function automatic int month_days(int mo, bit leap);
    if (mo < 1 || mo > 12) return 31;
    case (mo)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // tens digit in the high nibble, units in the low nibble
  function automatic int bcd(int v);
    return ((v / 10) << 4) | (v % 10);
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: register copy, local time prediction, in-order compare
  // --------------------------------------------------------------------------
  class tz_scoreboard;
    int    offset_hr;
    bit    dst_on;
    int    errors;
    wall_t due_times[$];

    function new();
      offset_hr = 0;
      dst_on    = 0;
      errors    = 0;
    endfunction

    function void set_reg(logic idx, logic [4:0] data);
      if (idx == CFG_UTC_OFFSET) offset_hr = int'($signed(data));
      if (idx == CFG_DST_ENABLE) dst_on = data[0];
    endfunction

    function wall_t to_local(utc_t s);
      int    yr, mo, day, hr, code, full;
      bit    leap, solid;
      wall_t w;
      yr   = int'(s.yr);
      mo   = int'(s.mo);
      day  = int'(s.day);
      hr   = int'(s.hr);
      code = int'(s.code);
      if (yr < 80) yr += 100;
      if (code == 0) code = 100;
      leap = (yr % 4) == 0;

      // offset, plus the daylight hour on days well inside summer time
      hr += offset_hr;
      solid = dst_on && code >= 2 && code <= 50;
      if (solid) hr++;

      // borrow one day
      if (hr < 0) begin
        hr += 24;
        day--;
        code++;
        if (day < 1) begin
          mo--;
          if (mo < 1) begin
            mo = 12;
            yr--;
          end
          day = month_days(mo, leap);
        end
      end
      // carry one day
      if (hr > 23) begin
        hr -= 24;
        day++;
        code--;
        if (day > month_days(mo, leap)) begin
          day = 1;
          mo++;
          if (mo > 12) begin
            mo = 1;
            yr++;
          end
        end
      end

      // transition days are corrected last
      if (dst_on && !solid) begin
        if (code == 51 && hr >= 2) hr++;
        if (code == 1 && hr < 2) hr++;
      end

      full          = yr + 1900;
      w.year_full   = 12'(full);
      w.month_out   = 4'(mo);
      w.day_out     = 5'(day);
      w.hour_out    = 5'(hr);
      w.century_bcd = 6'(bcd(full / 100));
      w.year_bcd    = 8'(bcd(full % 100));
      w.month_bcd   = 5'(bcd(mo));
      w.day_bcd     = 6'(bcd(day));
      w.hour_bcd    = 6'(bcd(hr));
      w.minute_bcd  = 7'(bcd(int'(s.minute)));
      w.second_bcd  = 7'(bcd(int'(s.second)));
      return w;
    endfunction

    function void log_request(utc_t s);
      due_times.push_back(to_local(s));
    endfunction

    function void diff(string name, logic [11:0] want, logic [11:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(wall_t got);
      wall_t want;
      if (due_times.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, expected none got %h",
                 $time, got);
        return;
      end
      want = due_times.pop_front();
      diff("year_full",   want.year_full,   got.year_full);
      diff("month_out",   want.month_out,   got.month_out);
      diff("day_out",     want.day_out,     got.day_out);
      diff("hour_out",    want.hour_out,    got.hour_out);
      diff("century_bcd", want.century_bcd, got.century_bcd);
      diff("year_bcd",    want.year_bcd,    got.year_bcd);
      diff("month_bcd",   want.month_bcd,   got.month_bcd);
      diff("day_bcd",     want.day_bcd,     got.day_bcd);
      diff("hour_bcd",    want.hour_bcd,    got.hour_bcd);
      diff("minute_bcd",  want.minute_bcd,  got.minute_bcd);
      diff("second_bcd",  want.second_bcd,  got.second_bcd);
    endfunction

    function int pending();
      return due_times.size();
    endfunction
  endclass

  tz_scoreboard sb;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("FAIL utc_to_local_time_with_dst_core");
      $finish;
    end
  end

  // monitor: register writes, accepted requests and accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.set_reg(cfg_index, cfg_data);
      if (out_valid && out_ready)
        sb.check_result({year_full, month_out, day_out, hour_out, century_bcd,
                         year_bcd, month_bcd, day_bcd, hour_bcd, minute_bcd,
                         second_bcd});
      if (in_valid && in_ready)
        sb.log_request({year_two_digit, month_in, day_in, hour_in, minute_in,
                        second_in, dst_code});
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic utc_t mk(int yr, int mo, int day, int hr, int mi, int se,
                              int code);
    utc_t s;
    s.yr     = 7'(yr);
    s.mo     = 4'(mo);
    s.day    = 5'(day);
    s.hr     = 5'(hr);
    s.minute = 6'(mi);
    s.second = 6'(se);
    s.code   = 7'(code);
    return s;
  endfunction

  // mostly well-formed timestamps biased to day, month and transition edges
  function automatic utc_t rand_stamp();
    utc_t s;
    int   yr, lim, pick;
    if ($urandom_range(9) == 0) begin
      s.yr     = 7'($urandom);
      s.mo     = 4'($urandom);
      s.day    = 5'($urandom);
      s.hr     = 5'($urandom);
      s.minute = 6'($urandom);
      s.second = 6'($urandom);
      s.code   = 7'($urandom);
      return s;
    end
    yr   = int'($urandom_range(99));
    s.yr = 7'(yr);
    s.mo = 4'($urandom_range(1, 12));
    lim  = month_days(int'(s.mo), (((yr < 80) ? yr + 100 : yr) % 4) == 0);
    pick = int'($urandom_range(9));
    if (pick < 3)      s.day = 5'd1;
    else if (pick < 6) s.day = 5'(lim);
    else               s.day = 5'($urandom_range(1, lim));
    pick = int'($urandom_range(9));
    if (pick < 3)      s.hr = 5'($urandom_range(0, 2));
    else if (pick < 6) s.hr = 5'($urandom_range(21, 23));
    else               s.hr = 5'($urandom_range(0, 23));
    s.minute = 6'($urandom_range(59));
    s.second = 6'($urandom_range(59));
    case ($urandom_range(7))
      0:       s.code = 7'd0;
      1:       s.code = 7'd1;
      2:       s.code = 7'd2;
      3:       s.code = 7'd50;
      4:       s.code = 7'd51;
      5:       s.code = 7'd52;
      default: s.code = 7'($urandom_range(99));
    endcase
    return s;
  endfunction

  // offer one request and hold it until accepted
  task automatic send(utc_t s);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    year_two_digit = s.yr;
    month_in       = s.mo;
    day_in         = s.day;
    hour_in        = s.hr;
    minute_in      = s.minute;
    second_in      = s.second;
    dst_code       = s.code;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, let every outstanding result come back, then let it settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic configure(int offset_hr, bit dst_on);
    drain();
    write_reg(CFG_UTC_OFFSET, 5'(offset_hr));
    write_reg(CFG_DST_ENABLE, {4'd0, dst_on});
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int offs [12];
    int off;

    sb             = new();
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_UTC_OFFSET;
    cfg_data       = 5'd0;
    in_valid       = 1'b0;
    year_two_digit = 7'd0;
    month_in       = 4'd1;
    day_in         = 5'd1;
    hour_in        = 5'd0;
    minute_in      = 6'd0;
    second_in      = 6'd0;
    dst_code       = 7'd0;
    cycle_cnt      = 0;
    hold_cycles    = 0;
    tx_idle_pct    = 29;
    rx_idle_pct    = 56;
    offs = '{-12, 12, 0, 5, -16, 15, -3, 9, 0, 0, 0, 0};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // westward offset: borrows across day, month and year
    configure(-12, 1'b1);
    send(mk(80, 1, 1, 0, 0, 0, 0));       // back into 1979
    send(mk(0, 1, 1, 5, 59, 59, 20));     // summer day, back into 1999
    send(mk(0, 3, 1, 3, 0, 0, 60));       // borrow into leap February
    send(mk(1, 3, 1, 3, 0, 0, 60));       // borrow into plain February
    send(mk(99, 7, 15, 23, 30, 30, 1));   // autumn change day, late hour
    send(mk(99, 7, 15, 13, 30, 30, 1));   // autumn change day, early hour
    send(mk(50, 10, 10, 20, 1, 2, 51));   // spring change day, late hour
    send(mk(50, 10, 10, 13, 1, 2, 51));   // spring change day, early hour
    send(mk(79, 6, 1, 0, 0, 0, 50));      // last summer code with borrow
    send(mk(127, 0, 0, 31, 63, 63, 127)); // top year, hour, min, sec and code
    send(mk(100, 15, 31, 0, 63, 0, 0));   // year above 99, month 15
    send(mk(0, 0, 1, 0, 0, 0, 99));       // month 0 borrows to December

    // eastward offset: carries across day, month and year
    configure(12, 1'b1);
    send(mk(79, 12, 31, 23, 0, 0, 0));    // forward into 2080
    send(mk(99, 12, 31, 14, 9, 9, 52));   // carry onto spring change day
    send(mk(11, 11, 23, 11, 0, 0, 51));   // hour reaches 24
    send(mk(0, 2, 28, 12, 0, 0, 3));      // leap day reached by carry
    send(mk(1, 2, 28, 12, 0, 0, 70));     // no leap day in 2001
    send(mk(4, 4, 30, 20, 0, 0, 2));      // first summer code with carry
    send(mk(5, 15, 31, 23, 0, 0, 0));     // month 15 carries to January
    send(mk(5, 1, 0, 12, 0, 0, 0));       // day 0 carries to day 1
    send(mk(5, 2, 31, 0, 0, 0, 0));       // day out of range, no carry

    // offset register at its raw extremes, daylight saving off
    configure(-16, 1'b0);
    send(mk(0, 1, 1, 0, 0, 0, 51));
    configure(15, 1'b0);
    send(mk(127, 12, 31, 31, 0, 0, 1));

    // random phases over settings and idling patterns
    for (int ph = 0; ph < 12; ph++) begin
      off = (ph >= 8) ? int'($urandom_range(24)) - 12 : offs[ph];
      configure(off, ph[0]);
      if (ph < 4) begin
        tx_idle_pct = 29;
        rx_idle_pct = 56;
      end else if (ph < 8) begin
        tx_idle_pct = 56;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // long receiver hold-off while requests keep coming
      if (ph == 2 || ph == 9) hold_cycles = 60;
      repeat (40) send(rand_stamp());
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS utc_to_local_time_with_dst_core");
    end else begin
      $display("FAIL utc_to_local_time_with_dst_core");
    end
    $finish;
  end

endmodule
